@@ rtl/pot_pkg.sv @@
// ----------------------------------------------------------------------------
// pot_pkg: shared types and constants of the point override table
// Command codes, payload beat structs and the controller command bundle.
// ----------------------------------------------------------------------------
package pot_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// fixed field widths
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;
	localparam int UC_W  = 5;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// command codes
	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_MODIFY = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_CLEAR  = 2'd3
	} pot_op_t;

	// input beat
	typedef struct packed {
		pot_op_t           command;
		logic [KEY_W-1:0]  point;
		logic [VAL_W-1:0]  value;
	} pot_in_t;

	// result beat
	typedef struct packed {
		logic              ok;
		logic [VAL_W-1:0]  stored_value;
		logic [UC_W-1:0]   used_count;
	} pot_out_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // capture a new input beat
		logic find;   // compare key against the table
		logic exec;   // update table and write the result
	} pot_cmd_t;

endpackage

@@ rtl/point_override_table.sv @@
// ----------------------------------------------------------------------------
// point_override_table: small associative key/value override table
// Lookup, modify or insert, remove with last-entry compaction, and clear.
// ----------------------------------------------------------------------------
// sequence: an accepted item gets a parallel key compare, then the table
//   write-back and its result beat; the next item is taken as the current
//   one retires, and a stalled result beat holds the write-back
// reset: entry count cleared, capacity back to 16; key and value storage
//   is not cleared, entries at or above the count are never read
module point_override_table (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  pot_pkg::pot_in_t          in_item,
	output logic                      out_valid,
	input  logic                      out_stall,
	output pot_pkg::pot_out_t         out_item,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [pot_pkg::CAP_W-1:0] cfg_data
);
	import pot_pkg::*;

	pot_cmd_t cmd;

	// capacity writes always land
	assign cfg_ready = 1'b1;

	pot_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	pot_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_item  (in_item),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.out_item (out_item)
	);

endmodule

@@ rtl/pot_ctrl.sv @@
// ----------------------------------------------------------------------------
// pot_ctrl: sequencing for the point override table
// Steps each item through a key search and a write-back, and owns the
// input stall and the result valid flag.
// ----------------------------------------------------------------------------
module pot_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output pot_pkg::pot_cmd_t cmd
);
	import pot_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FIND,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// result register can take a new beat this cycle
	assign out_free = !out_valid_q || !out_stall;

	// a new item enters when idle or when the current one retires
	assign in_stall = !((state_q == S_IDLE) || ((state_q == S_EXEC) && out_free));

	// commands to the datapath
	assign cmd.load = in_valid && !in_stall;
	assign cmd.find = (state_q == S_FIND);
	assign cmd.exec = (state_q == S_EXEC) && out_free;

	assign out_valid = out_valid_q;

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= in_valid ? S_FIND : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/pot_dpath.sv @@
// ----------------------------------------------------------------------------
// pot_dpath: storage and compare logic of the point override table
// Holds keys, values, the fill count and the capacity register; runs the
// parallel key search and the per-command table update.
// ----------------------------------------------------------------------------
module pot_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  pot_pkg::pot_cmd_t cmd,
	input  pot_pkg::pot_in_t  in_item,
	input  logic              cfg_wr,
	input  logic [pot_pkg::CAP_W-1:0] cfg_data,
	output pot_pkg::pot_out_t out_item
);
	import pot_pkg::*;

	pot_in_t          item_q;
	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] used_q;
	logic [KEY_W-1:0] keys_q [TABLE_DEPTH];
	logic [VAL_W-1:0] vals_q [TABLE_DEPTH];
	pot_out_t         out_q;

	logic             hit_s1;
	logic [IDX_W-1:0] slot_s1;

	logic [TABLE_DEPTH-1:0] match;
	logic                   hit_c;
	logic [IDX_W-1:0]       slot_c;

	logic [CNT_W-1:0] eff_lim;
	logic [CNT_W-1:0] last_cnt;
	logic [IDX_W-1:0] last_idx;
	logic [IDX_W-1:0] rd_idx;
	logic [VAL_W-1:0] rd_val;
	logic [KEY_W-1:0] last_key;

	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [KEY_W-1:0] wr_key;
	logic [VAL_W-1:0] wr_val;
	logic [CNT_W-1:0] used_nx;
	pot_out_t         res;
	logic [31:0]      used_wide;

	// capacity saturates at the table depth
	always_comb begin
		if (32'(cap_q) > 32'(TABLE_DEPTH)) begin
			eff_lim = CNT_W'(TABLE_DEPTH);
		end else begin
			eff_lim = CNT_W'(cap_q);
		end
	end

	// parallel key compare over used entries, lowest slot wins
	always_comb begin
		hit_c  = 1'b0;
		slot_c = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			match[i] = (32'(i) < 32'(used_q)) && (keys_q[i] == item_q.point);
		end
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_c  = 1'b1;
				slot_c = IDX_W'(i);
			end
		end
	end

	// last used entry and the single value read port
	assign last_cnt = used_q - CNT_W'(1);
	assign last_idx = last_cnt[IDX_W-1:0];
	assign rd_idx   = (item_q.command == CMD_REMOVE) ? last_idx : slot_s1;
	assign rd_val   = vals_q[rd_idx];
	assign last_key = keys_q[last_idx];

	// per-command update and result
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = slot_s1;
		wr_key  = item_q.point;
		wr_val  = item_q.value;
		used_nx = used_q;
		res.ok           = 1'b0;
		res.stored_value = '0;
		unique case (item_q.command)
			CMD_LOOKUP: begin
				if (hit_s1) begin
					res.ok           = 1'b1;
					res.stored_value = rd_val;
				end
			end
			CMD_MODIFY: begin
				if (hit_s1) begin
					wr_en  = 1'b1;
					res.ok = 1'b1;
				end else if (used_q < eff_lim) begin
					wr_en   = 1'b1;
					wr_idx  = used_q[IDX_W-1:0];
					used_nx = used_q + CNT_W'(1);
					res.ok  = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (hit_s1) begin
					// move the last entry into the freed slot
					wr_en   = (slot_s1 != last_idx);
					wr_key  = last_key;
					wr_val  = rd_val;
					used_nx = last_cnt;
					res.ok  = 1'b1;
				end
			end
			CMD_CLEAR: begin
				used_nx = '0;
				res.ok  = 1'b1;
			end
			default: begin
				res.ok = 1'b0;
			end
		endcase
		used_wide      = 32'(used_nx);
		res.used_count = used_wide[UC_W-1:0];
	end

	// control state: count and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			cap_q  <= CAP_RESET;
		end else begin
			if (cfg_wr) begin
				cap_q <= cfg_data;
			end
			if (cmd.exec) begin
				used_q <= used_nx;
			end
		end
	end

	// payload registers: item, search result, table, result beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
		end
		if (cmd.find) begin
			hit_s1  <= hit_c;
			slot_s1 <= slot_c;
		end
		if (cmd.exec) begin
			out_q <= res;
			if (wr_en) begin
				keys_q[wr_idx] <= wr_key;
				vals_q[wr_idx] <= wr_val;
			end
		end
	end

	assign out_item = out_q;

endmodule

@@ test/override_table_checker.sv @@
// ----------------------------------------------------------------------------
// override_table_checker: result checker of the point override table
// Watches the input, result and capacity channels, keeps its own copy of the
// table and the capacity, and compares every result beat field by field with
// the oldest predicted beat. Counts mismatches and reports the beats in flight.
// ----------------------------------------------------------------------------
module override_table_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  pot_pkg::pot_in_t          in_item,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  pot_pkg::pot_out_t         out_item,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [pot_pkg::CAP_W-1:0] cfg_data,
	output int                        mismatches,
	output int                        pending
);
	import pot_pkg::*;

	// shadow copy of the table
	logic [KEY_W-1:0] table_keys [TABLE_DEPTH];
	logic [VAL_W-1:0] table_vals [TABLE_DEPTH];
	int               table_used;
	logic [CAP_W-1:0] cap_limit;

	// predicted result beats, oldest first
	pot_out_t expected_results [$];

	// apply one command to the shadow table and form its result beat
	task automatic apply_command(input pot_in_t cmd, output pot_out_t res);
		int  i;
		int  slot;
		int  room;
		bit  hit;
		hit  = 1'b0;
		slot = 0;
		res  = '0;
		// first used entry holding the key
		for (i = 0; i < table_used; i++) begin
			if (!hit && table_keys[i] == cmd.point) begin
				hit  = 1'b1;
				slot = i;
			end
		end
		// capacity saturates at the table depth
		room = (int'(cap_limit) > TABLE_DEPTH) ? TABLE_DEPTH : int'(cap_limit);
		case (cmd.command)
			CMD_LOOKUP: begin
				if (hit) begin
					res.ok           = 1'b1;
					res.stored_value = table_vals[slot];
				end
			end
			CMD_MODIFY: begin
				// new key is appended only while below the limit
				if (!hit && table_used < room) begin
					slot = table_used;
					table_used++;
					hit = 1'b1;
				end
				if (hit) begin
					table_keys[slot] = cmd.point;
					table_vals[slot] = cmd.value;
					res.ok           = 1'b1;
				end
			end
			CMD_REMOVE: begin
				// last entry fills the freed slot
				if (hit) begin
					if (slot != table_used - 1) begin
						table_keys[slot] = table_keys[table_used - 1];
						table_vals[slot] = table_vals[table_used - 1];
					end
					table_used--;
					res.ok = 1'b1;
				end
			end
			default: begin
				table_used = 0;
				res.ok     = 1'b1;
			end
		endcase
		res.used_count = UC_W'(table_used);
	endtask

	// track beats at each edge
	always @(posedge clk or negedge arst_n) begin
		pot_out_t want;
		if (!arst_n) begin
			table_used = 0;
			cap_limit  = CAP_RESET;
			expected_results.delete();
			pending    = 0;
			mismatches = 0;
		end else begin
			// capacity write
			if (cfg_valid && cfg_ready)
				cap_limit = cfg_data;
			// result beat against the oldest prediction
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no pending command: ok %0d value %h count %0d",
						out_item.ok, out_item.stored_value, out_item.used_count);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (out_item.ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, out_item.ok);
						mismatches++;
					end
					if (out_item.stored_value !== want.stored_value) begin
						$error("stored_value: expected %h, got %h",
							want.stored_value, out_item.stored_value);
						mismatches++;
					end
					if (out_item.used_count !== want.used_count) begin
						$error("used_count: expected %0d, got %0d",
							want.used_count, out_item.used_count);
						mismatches++;
					end
				end
			end
			// command beat updates the shadow table
			if (in_valid && !in_stall) begin
				apply_command(in_item, want);
				expected_results.push_back(want);
			end
			pending = expected_results.size();
		end
	end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: top level test of the point override table
// Drives directed and random command beats under changing capacity limits
// and random idle and stall patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
	import pot_pkg::*;

	localparam int POOL_SIZE   = 20;
	localparam int SEGMENTS    = 6;
	localparam int SEG_BEATS   = 285;

	logic             clk        = 1'b0;
	logic             arst_n     = 1'b0;
	logic             in_valid   = 1'b0;
	logic             in_stall;
	pot_in_t          in_item    = '0;
	logic             out_valid;
	logic             out_stall  = 1'b0;
	pot_out_t         out_item;
	logic             cfg_valid  = 1'b0;
	logic             cfg_ready;
	logic [CAP_W-1:0] cfg_data   = '0;
	int               mismatches;
	int               pending;

	// idle and stall rates in percent
	int send_gap_pct   = 0;
	int recv_stall_pct = 0;

	// keys reused so that lookups and removes hit
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	// capacity per random segment: full field, one, zero, depth, small, above depth
	logic [CAP_W-1:0] cap_plan [SEGMENTS] = '{5'd31, 5'd1, 5'd0, 5'd16, 5'd5, 5'd17};

	always #1 clk = ~clk;

	point_override_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	override_table_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// receiver stalls
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	function automatic pot_in_t beat(input pot_op_t op, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] val);
		pot_in_t b;
		b.command = op;
		b.point   = key;
		b.value   = val;
		return b;
	endfunction

	// mostly pooled keys, some fully random ones; clears kept rare
	function automatic pot_in_t random_beat();
		int      roll;
		pot_in_t b;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			b.command = CMD_LOOKUP;
		else if (roll < 70)
			b.command = CMD_MODIFY;
		else if (roll < 98)
			b.command = CMD_REMOVE;
		else
			b.command = CMD_CLEAR;
		if ($urandom_range(0, 99) < 85)
			b.point = key_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			b.point = $urandom();
		b.value = $urandom();
		return b;
	endfunction

	// hold one command beat until it is taken
	task automatic send_beat(input pot_in_t b);
		bit taken;
		in_item  <= b;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// stop sending until every predicted result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	// capacity write, only with the table idle
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		bit taken;
		wait_drained();
		cfg_data  <= cap;
		cfg_valid <= 1'b1;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
	endtask

	// stimulus and verdict
	initial begin
		int s;
		int n;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extreme keys and values, update, compaction, clear
		send_beat(beat(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000));
		send_beat(beat(CMD_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF));
		send_beat(beat(CMD_MODIFY, 32'h0000_0000, 32'hFFFF_FFFF));
		send_beat(beat(CMD_MODIFY, 32'hFFFF_FFFF, 32'h0000_0000));
		send_beat(beat(CMD_MODIFY, 32'h5A5A_5A5A, 32'hA5A5_A5A5));
		send_beat(beat(CMD_MODIFY, 32'h1234_5678, 32'h8765_4321));
		send_beat(beat(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_beat(beat(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000));
		send_beat(beat(CMD_MODIFY, 32'h0000_0000, 32'h1357_9BDF));
		send_beat(beat(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF));
		send_beat(beat(CMD_LOOKUP, 32'h0000_0007, 32'h0000_0000));
		// remove from the middle moves the last entry down
		send_beat(beat(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000));
		send_beat(beat(CMD_LOOKUP, 32'h1234_5678, 32'h0000_0000));
		send_beat(beat(CMD_LOOKUP, 32'h5A5A_5A5A, 32'h0000_0000));
		send_beat(beat(CMD_REMOVE, 32'h1234_5678, 32'hFFFF_FFFF));
		send_beat(beat(CMD_REMOVE, 32'h1234_5678, 32'h0000_0000));
		send_beat(beat(CMD_LOOKUP, 32'h5A5A_5A5A, 32'h0000_0000));
		send_beat(beat(CMD_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_beat(beat(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000));
		send_beat(beat(CMD_CLEAR,  32'h0000_0000, 32'h0000_0000));
		send_beat(beat(CMD_MODIFY, 32'hDEAD_BEEF, 32'hFFFF_FFFF));
		send_beat(beat(CMD_LOOKUP, 32'hDEAD_BEEF, 32'h0000_0000));

		// random segments; table is not cleared between them so a lower limit
		// meets a fuller table
		for (s = 0; s < SEGMENTS; s++) begin
			write_capacity(cap_plan[s]);
			send_gap_pct   = (s < 2) ? 22 : (s < 4) ? 55 : 0;
			recv_stall_pct = (s < 2) ? 55 : (s < 4) ? 22 : 0;
			foreach (key_pool[k])
				key_pool[k] = $urandom();
			for (n = 0; n < SEG_BEATS; n++) begin
				if ($urandom_range(0, 59) == 0)
					wait_drained();
				while ($urandom_range(0, 99) < send_gap_pct) begin
					in_valid <= 1'b0;
					@(posedge clk);
				end
				send_beat(random_beat());
			end
		end

		// let the last results out, then a short quiet window
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("** point_override_table: PASSED **");
		else
			$display("** point_override_table: FAILED **");
		$finish;
	end

	// run time limit
	initial begin
		#2000000;
		$display("** point_override_table: FAILED **");
		$finish;
	end

endmodule
